FILE: hdl/reader_writer_lock_arbiter_top_macros.svh
// Assertion macros for the reader-writer lock arbiter checker.
// Expects clk and rst_n in the scope of each use.
`ifndef READER_WRITER_LOCK_ARBITER_TOP_MACROS_SVH
`define READER_WRITER_LOCK_ARBITER_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define RWLA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define RWLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rwla_pkg.sv
// Shared types and constants of the reader-writer lock arbiter.
// No dependencies; imported by every module of the block.
`default_nettype none

package rwla_pkg;

    localparam int OPCODE_W  = 3;
    localparam int ID_PORT_W = 8;
    localparam int HOLD_W    = 16;
    localparam int MAX_WAKE  = 16;

    localparam logic signed [HOLD_W-1:0] HOLD_MAX    = 16'sh7FFF;
    localparam logic signed [HOLD_W-1:0] HOLD_WRITER = 16'shFFFF;
    localparam logic signed [HOLD_W-1:0] HOLD_ONE    = 16'sh0001;

    typedef enum logic [OPCODE_W-1:0] {
        OP_READ      = 3'd0,
        OP_TRY_READ  = 3'd1,
        OP_WRITE     = 3'd2,
        OP_TRY_WRITE = 3'd3,
        OP_REL_READ  = 3'd4,
        OP_REL_WRITE = 3'd5,
        OP_DOWNGRADE = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        EV_GRANTED     = 3'd0,
        EV_QUEUED      = 3'd1,
        EV_TRY_FAILED  = 3'd2,
        EV_RELEASED    = 3'd3,
        EV_WOKE_READER = 3'd4,
        EV_WOKE_WRITER = 3'd5,
        EV_REFUSED     = 3'd6
    } ev_kind_t;

    typedef enum logic [2:0] {
        CMD_READ,
        CMD_WRITE,
        CMD_REL_READ,
        CMD_REL_WRITE,
        CMD_DOWNGRADE,
        CMD_BAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      is_try;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic single;
        logic head_writer;
        logic next_writer;
    } wq_status_t;

endpackage

`default_nettype wire

FILE: hdl/rwla_front.sv
// Front end: accepts requests, classifies the opcode and holds up to two commands.
// Depends on rwla_pkg.
`default_nettype none

module rwla_front
    import rwla_pkg::*;
#(
    parameter int IdW = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire logic [OPCODE_W-1:0]  opcode,
    input  wire logic [ID_PORT_W-1:0] requester_id,
    output logic                      cmd_valid,
    output cmd_t                      cmd,
    output logic [IdW-1:0]            cmd_id,
    input  wire logic                 cmd_pop
);

    cmd_t           cmd_dec;
    cmd_t           cmd_mem [2];
    logic [IdW-1:0] id_mem  [2];
    logic [1:0]     count_reg, count_next;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic           accept;

    assign req_stall = (count_reg == 2'd2);
    assign accept    = req_valid && !req_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = cmd_mem[rd_ptr_reg];
    assign cmd_id    = id_mem[rd_ptr_reg];

    always_comb
    begin
        cmd_dec.kind   = CMD_BAD;
        cmd_dec.is_try = (opcode == OP_TRY_READ) || (opcode == OP_TRY_WRITE);
        unique case (opcode) inside
            OP_READ, OP_TRY_READ:   cmd_dec.kind = CMD_READ;
            OP_WRITE, OP_TRY_WRITE: cmd_dec.kind = CMD_WRITE;
            OP_REL_READ:            cmd_dec.kind = CMD_REL_READ;
            OP_REL_WRITE:           cmd_dec.kind = CMD_REL_WRITE;
            OP_DOWNGRADE:           cmd_dec.kind = CMD_DOWNGRADE;
            default:                cmd_dec.kind = CMD_BAD;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (accept && !cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!accept && cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_mem[wr_ptr_reg] <= cmd_dec;
            id_mem[wr_ptr_reg]  <= requester_id[IdW-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rwla_waitq.sv
// Waiter queue: circular memory of waiting ids with reader/writer marks.
// Keeps the head and the entry after it in registers. Depends on rwla_pkg.
`default_nettype none

module rwla_waitq
    import rwla_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int IdW         = 8
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire logic [IdW-1:0] push_id,
    input  wire logic           push_writer,
    input  wire logic           pop,
    output wq_status_t          status,
    output logic [IdW-1:0]      head_id
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int OccW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastIdx = PtrW'(QUEUE_DEPTH - 1);

    logic [IdW:0]      entry_mem [QUEUE_DEPTH];
    logic [IdW:0]      head_entry_reg;
    logic [IdW:0]      next_entry_reg;
    logic [IdW:0]      wr_data;
    logic [PtrW-1:0]   head_ptr_reg, head_ptr_next;
    logic [PtrW-1:0]   tail_ptr_reg, tail_ptr_next;
    logic [PtrW-1:0]   after_ptr;
    logic [OccW-1:0]   occ_reg, occ_next;

    function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
        return (p == LastIdx) ? '0 : p + 1'b1;
    endfunction

    assign wr_data       = {push_writer, push_id};
    assign head_ptr_next = pop ? bump(head_ptr_reg) : head_ptr_reg;
    assign tail_ptr_next = push ? bump(tail_ptr_reg) : tail_ptr_reg;
    assign after_ptr     = bump(head_ptr_next);

    always_comb
    begin
        occ_next = occ_reg;
        if (push && !pop)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg <= '0;
            tail_ptr_reg <= '0;
            occ_reg      <= '0;
        end
        else
        begin
            head_ptr_reg <= head_ptr_next;
            tail_ptr_reg <= tail_ptr_next;
            occ_reg      <= occ_next;
        end
    end

    // Forward a write that lands on the entry about to be read.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[tail_ptr_reg] <= wr_data;
        end
        head_entry_reg <= (push && tail_ptr_reg == head_ptr_next) ?
                          wr_data : entry_mem[head_ptr_next];
        next_entry_reg <= (push && tail_ptr_reg == after_ptr) ?
                          wr_data : entry_mem[after_ptr];
    end

    assign status.empty       = (occ_reg == '0);
    assign status.full        = (occ_reg == OccW'(QUEUE_DEPTH));
    assign status.single      = (occ_reg == OccW'(1));
    assign status.head_writer = head_entry_reg[IdW];
    assign status.next_writer = next_entry_reg[IdW];
    assign head_id            = head_entry_reg[IdW-1:0];

endmodule

`default_nettype wire

FILE: hdl/rwla_back.sv
// Back end: hold count, grant and wake sequencer, result register.
// Drives the waiter queue. Depends on rwla_pkg.
`default_nettype none

module rwla_back
    import rwla_pkg::*;
#(
    parameter int IdW = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    input  cmd_t                      cmd,
    input  wire logic [IdW-1:0]       cmd_id,
    output logic                      cmd_pop,
    input  wq_status_t                wq_status,
    input  wire logic [IdW-1:0]       head_id,
    output logic                      wq_push,
    output logic                      wq_push_writer,
    output logic                      wq_pop,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output logic [2:0]                event_kind,
    output logic [ID_PORT_W-1:0]      task_id,
    output logic signed [HOLD_W-1:0]  hold_count,
    output logic                      last
);

    localparam int WakeCntW = $clog2(MAX_WAKE);
    localparam logic [WakeCntW-1:0] WakeCntLast = WakeCntW'(MAX_WAKE - 1);

    typedef enum logic {
        ST_IDLE,
        ST_WAKE
    } state_t;

    state_t                    state_reg, state_next;
    logic signed [HOLD_W-1:0]  holders_reg, holders_next;
    logic [WakeCntW-1:0]       wake_cnt_reg, wake_cnt_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    ev_kind_t                  kind_reg, kind_next;
    logic [IdW-1:0]            id_reg, id_next;
    logic signed [HOLD_W-1:0]  hold_reg, hold_next;
    logic                      last_reg, last_next;
    logic                      out_ready;
    logic                      run_last;
    logic                      do_wake;
    logic                      allow_writer;
    logic signed [HOLD_W-1:0]  base;

    assign out_ready = !rsp_valid_reg || !rsp_stall;
    assign run_last  = wq_status.single || wq_status.next_writer;

    always_comb
    begin
        state_next     = state_reg;
        holders_next   = holders_reg;
        wake_cnt_next  = wake_cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        kind_next      = kind_reg;
        id_next        = id_reg;
        hold_next      = hold_reg;
        last_next      = last_reg;
        cmd_pop        = 1'b0;
        wq_push        = 1'b0;
        wq_push_writer = 1'b0;
        wq_pop         = 1'b0;
        do_wake        = 1'b0;
        allow_writer   = 1'b0;
        base           = holders_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_ready)
                begin
                    cmd_pop        = 1'b1;
                    rsp_valid_next = 1'b1;
                    last_next      = 1'b1;
                    id_next        = cmd_id;
                    kind_next      = EV_REFUSED;
                    unique case (cmd.kind)
                        CMD_READ:
                        begin
                            if (!holders_reg[HOLD_W-1] && wq_status.empty)
                            begin
                                if (holders_reg != HOLD_MAX)
                                begin
                                    holders_next = holders_reg + HOLD_ONE;
                                    kind_next    = EV_GRANTED;
                                end
                            end
                            else if (cmd.is_try)
                            begin
                                kind_next = EV_TRY_FAILED;
                            end
                            else if (!wq_status.full)
                            begin
                                wq_push   = 1'b1;
                                kind_next = EV_QUEUED;
                            end
                        end
                        CMD_WRITE:
                        begin
                            if (holders_reg == '0 && wq_status.empty)
                            begin
                                holders_next = HOLD_WRITER;
                                kind_next    = EV_GRANTED;
                            end
                            else if (cmd.is_try)
                            begin
                                kind_next = EV_TRY_FAILED;
                            end
                            else if (!wq_status.full)
                            begin
                                wq_push        = 1'b1;
                                wq_push_writer = 1'b1;
                                kind_next      = EV_QUEUED;
                            end
                        end
                        CMD_REL_READ:
                        begin
                            if (holders_reg == HOLD_ONE)
                            begin
                                do_wake      = 1'b1;
                                allow_writer = 1'b1;
                                base         = '0;
                            end
                            else if (!holders_reg[HOLD_W-1] && holders_reg != '0)
                            begin
                                holders_next = holders_reg - HOLD_ONE;
                                kind_next    = EV_RELEASED;
                            end
                        end
                        CMD_REL_WRITE:
                        begin
                            do_wake      = 1'b1;
                            allow_writer = 1'b1;
                            base         = '0;
                        end
                        CMD_DOWNGRADE:
                        begin
                            do_wake = 1'b1;
                            base    = HOLD_ONE;
                        end
                        default:
                        begin
                            kind_next = EV_REFUSED;
                        end
                    endcase
                    if (do_wake)
                    begin
                        holders_next = base;
                        kind_next    = EV_RELEASED;
                        if (!wq_status.empty)
                        begin
                            if (wq_status.head_writer)
                            begin
                                if (allow_writer)
                                begin
                                    holders_next = HOLD_WRITER;
                                    kind_next    = EV_WOKE_WRITER;
                                    id_next      = head_id;
                                    wq_pop       = 1'b1;
                                end
                            end
                            else
                            begin
                                holders_next = base + HOLD_ONE;
                                kind_next    = EV_WOKE_READER;
                                id_next      = head_id;
                                wq_pop       = 1'b1;
                                last_next    = run_last;
                                if (!run_last)
                                begin
                                    state_next    = ST_WAKE;
                                    wake_cnt_next = WakeCntW'(1);
                                end
                            end
                        end
                    end
                    hold_next = holders_next;
                end
            end
            ST_WAKE:
            begin
                if (out_ready)
                begin
                    rsp_valid_next = 1'b1;
                    kind_next      = EV_WOKE_READER;
                    id_next        = head_id;
                    wq_pop         = 1'b1;
                    if (holders_reg != HOLD_MAX)
                    begin
                        holders_next = holders_reg + HOLD_ONE;
                    end
                    hold_next     = holders_next;
                    last_next     = run_last || (wake_cnt_reg == WakeCntLast);
                    wake_cnt_next = wake_cnt_reg + 1'b1;
                    if (last_next)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            holders_reg   <= '0;
            wake_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            kind_reg      <= EV_GRANTED;
            id_reg        <= '0;
            hold_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            holders_reg   <= holders_next;
            wake_cnt_reg  <= wake_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            kind_reg      <= kind_next;
            id_reg        <= id_next;
            hold_reg      <= hold_next;
            last_reg      <= last_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign event_kind = kind_reg;
    assign task_id    = ID_PORT_W'(id_reg);
    assign hold_count = hold_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

FILE: hdl/reader_writer_lock_arbiter_top.sv
// Reader-writer lock arbiter top level: front end, waiter queue and back end.
// Depends on rwla_pkg, rwla_front, rwla_waitq and rwla_back.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   opcode, requester_id
//   rsp      out        rsp_valid/rsp_stall   event_kind, task_id, hold_count, last
//
// An accepted request waits in the front queue, then the back end decides it and
// registers its first result. Results leave at up to one per cycle.
// A wake run emits one woken reader per cycle unless rsp_stall holds it (at most 16),
// paced by the waiter memory's registered head and next-entry reads.
// Reset clears the hold count, pointers and control; the waiter memory is not cleared.
// The front queue holds two requests; rsp_stall holds the result register and back end.
`default_nettype none

module reader_writer_lock_arbiter_top
    import rwla_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 16,
    parameter int TASK_ID_BITS = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire logic [OPCODE_W-1:0]  opcode,
    input  wire logic [ID_PORT_W-1:0] requester_id,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output logic [2:0]                event_kind,
    output logic [ID_PORT_W-1:0]      task_id,
    output logic signed [HOLD_W-1:0]  hold_count,
    output logic                      last
);

    localparam int IdW = (TASK_ID_BITS < ID_PORT_W) ? TASK_ID_BITS : ID_PORT_W;

    logic           cmd_valid;
    cmd_t           cmd;
    logic [IdW-1:0] cmd_id;
    logic           cmd_pop;
    wq_status_t     wq_status;
    logic [IdW-1:0] head_id;
    logic           wq_push;
    logic           wq_push_writer;
    logic           wq_pop;

    rwla_front #(
        .IdW (IdW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .opcode       (opcode),
        .requester_id (requester_id),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_id       (cmd_id),
        .cmd_pop      (cmd_pop)
    );

    rwla_waitq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IdW         (IdW)
    ) u_waitq (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (wq_push),
        .push_id     (cmd_id),
        .push_writer (wq_push_writer),
        .pop         (wq_pop),
        .status      (wq_status),
        .head_id     (head_id)
    );

    rwla_back #(
        .IdW (IdW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_id         (cmd_id),
        .cmd_pop        (cmd_pop),
        .wq_status      (wq_status),
        .head_id        (head_id),
        .wq_push        (wq_push),
        .wq_push_writer (wq_push_writer),
        .wq_pop         (wq_pop),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .event_kind     (event_kind),
        .task_id        (task_id),
        .hold_count     (hold_count),
        .last           (last)
    );

endmodule

`default_nettype wire

FILE: hdl/rwla_checker.sv
// Port-level checker for the reader-writer lock arbiter, bound to the top level.
// Depends on rwla_pkg and reader_writer_lock_arbiter_top_macros.svh.
`default_nettype none

`include "reader_writer_lock_arbiter_top_macros.svh"

module rwla_checker
    import rwla_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_stall,
    input wire logic [2:0]           event_kind,
    input wire logic [ID_PORT_W-1:0] task_id,
    input wire logic signed [HOLD_W-1:0] hold_count,
    input wire logic                 last
);

    logic [ID_PORT_W+HOLD_W+3:0] rsp_data;
    logic                        rsp_held;
    logic                        run_more;
    logic                        woke_reader;
    logic                        woke_writer;
    logic                        writer_held;
    logic                        readers_held;

    assign rsp_data     = {event_kind, task_id, hold_count, last};
    assign rsp_held     = rsp_valid && rsp_stall;
    assign run_more     = rsp_valid && !rsp_stall && !last;
    assign woke_reader  = rsp_valid && (event_kind == EV_WOKE_READER);
    assign woke_writer  = rsp_valid && (event_kind == EV_WOKE_WRITER);
    assign writer_held  = (hold_count == HOLD_WRITER);
    assign readers_held = !hold_count[HOLD_W-1] && (hold_count != '0);

    `RWLA_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_data), "stalled result changed")
    `RWLA_ASSERT_NEXT(a_wake_run, run_more, rsp_valid && woke_reader, "wake run broke off")
    `RWLA_ASSERT_SAME(a_woke_writer, woke_writer, last && writer_held, "writer count missing")
    `RWLA_ASSERT_SAME(a_single_result, rsp_valid && !woke_reader, last, "non-wake result not final")
    `RWLA_ASSERT_SAME(a_reader_count, woke_reader, readers_held, "woken reader, no readers held")

endmodule

bind reader_writer_lock_arbiter_top rwla_checker u_checker (.*);

`default_nettype wire

FILE: tb/reader_writer_lock_arbiter_top_tb.sv
// Self-checking testbench for reader_writer_lock_arbiter_top: directed table, then random traffic.
// Expected events come from typed table rows or an in-bench lock and waiter-queue predictor; depends on rwla_pkg.
module reader_writer_lock_arbiter_top_tb;
    import rwla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WQ_DEPTH     = 16;
    localparam int          RANDOM_ITEMS = 396;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          REPORT_W     = HOLD_W + 1;
    localparam logic [2:0]  OPC_UNUSED   = 3'd7;

    typedef struct packed {
        ev_kind_t                kind;
        logic [ID_PORT_W-1:0]    tid;
        logic signed [HOLD_W-1:0] hold;
        logic                    last;
    } lock_event_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]      op;
        logic [ID_PORT_W-1:0]     rid;
        int                       reps;
        bit                       rand_rid;
        bit                       typed;
        ev_kind_t                 kind;
        logic signed [HOLD_W-1:0] hold;
    } plan_row_t;

    localparam plan_row_t DIRECTED_PLAN [24] = '{
        '{OP_REL_READ,  8'h00, 1,     1'b0, 1'b1, EV_REFUSED,     16'sd0},
        '{OPC_UNUSED,   8'hFF, 1,     1'b0, 1'b1, EV_REFUSED,     16'sd0},
        '{OP_REL_WRITE, 8'h5A, 1,     1'b0, 1'b1, EV_RELEASED,    16'sd0},
        '{OP_DOWNGRADE, 8'hA5, 1,     1'b0, 1'b1, EV_RELEASED,    HOLD_ONE},
        '{OP_REL_READ,  8'h01, 1,     1'b0, 1'b1, EV_RELEASED,    16'sd0},
        '{OP_TRY_READ,  8'h80, 1,     1'b0, 1'b1, EV_GRANTED,     HOLD_ONE},
        '{OP_TRY_WRITE, 8'h7F, 1,     1'b0, 1'b1, EV_TRY_FAILED,  HOLD_ONE},
        '{OP_WRITE,     8'h11, 1,     1'b0, 1'b1, EV_QUEUED,      HOLD_ONE},
        '{OP_READ,      8'h00, 3,     1'b1, 1'b0, EV_GRANTED,     16'sd0},
        '{OP_TRY_READ,  8'h33, 1,     1'b0, 1'b1, EV_TRY_FAILED,  HOLD_ONE},
        '{OP_REL_READ,  8'h02, 1,     1'b0, 1'b0, EV_GRANTED,     16'sd0},
        '{OP_REL_WRITE, 8'h11, 1,     1'b0, 1'b0, EV_GRANTED,     16'sd0},
        '{OP_REL_READ,  8'h00, 3,     1'b1, 1'b0, EV_GRANTED,     16'sd0},
        '{OP_WRITE,     8'h44, 1,     1'b0, 1'b1, EV_GRANTED,     HOLD_WRITER},
        '{OP_WRITE,     8'h00, 16,    1'b1, 1'b0, EV_GRANTED,     16'sd0},
        '{OP_READ,      8'hEE, 1,     1'b0, 1'b1, EV_REFUSED,     HOLD_WRITER},
        '{OP_DOWNGRADE, 8'hDD, 1,     1'b0, 1'b0, EV_GRANTED,     16'sd0},
        '{OP_REL_WRITE, 8'h00, 17,    1'b1, 1'b0, EV_GRANTED,     16'sd0},
        '{OP_WRITE,     8'h01, 1,     1'b0, 1'b1, EV_GRANTED,     HOLD_WRITER},
        '{OP_READ,      8'h00, 16,    1'b1, 1'b0, EV_GRANTED,     16'sd0},
        '{OP_TRY_WRITE, 8'hC3, 1,     1'b0, 1'b1, EV_TRY_FAILED,  HOLD_WRITER},
        '{OP_REL_WRITE, 8'h01, 1,     1'b0, 1'b0, EV_GRANTED,     16'sd0},
        '{OP_REL_WRITE, 8'h02, 1,     1'b0, 1'b1, EV_RELEASED,    16'sd0},
        '{OP_REL_WRITE, 8'h97, 1,     1'b0, 1'b1, EV_RELEASED,    16'sd0}
    };

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     req_valid    = 1'b0;
    logic                     req_stall;
    logic [OPCODE_W-1:0]      opcode       = '0;
    logic [ID_PORT_W-1:0]     requester_id = '0;
    logic                     rsp_valid;
    logic                     rsp_stall    = 1'b0;
    logic [2:0]               event_kind;
    logic [ID_PORT_W-1:0]     task_id;
    logic signed [HOLD_W-1:0] hold_count;
    logic                     last;

    bit                       typed_on   = 1'b0;
    ev_kind_t                 typed_kind = EV_GRANTED;
    logic signed [HOLD_W-1:0] typed_hold = '0;
    bit                       calm       = 1'b0;
    int                       err_count  = 0;
    int                       cycles     = 0;

    logic signed [HOLD_W-1:0] hold_cnt = '0;
    logic [ID_PORT_W-1:0]     wq_id [WQ_DEPTH];
    bit                       wq_wr [WQ_DEPTH];
    int                       wq_head  = 0;
    int                       wq_tail  = 0;
    int                       wq_count = 0;

    lock_event_t              step_events [$];
    lock_event_t              lock_events_due [$];

    reader_writer_lock_arbiter_top #(
        .QUEUE_DEPTH  (WQ_DEPTH),
        .TASK_ID_BITS (8)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .opcode       (opcode),
        .requester_id (requester_id),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .event_kind   (event_kind),
        .task_id      (task_id),
        .hold_count   (hold_count),
        .last         (last)
    );

    always #5 clk = ~clk;

    function automatic void emit_event(ev_kind_t k, logic [ID_PORT_W-1:0] rid);
        step_events.push_back('{k, rid, hold_cnt, 1'b0});
    endfunction

    function automatic bit push_waiter(logic [ID_PORT_W-1:0] rid, bit writer);
        if (wq_count >= WQ_DEPTH)
            return 1'b0;
        wq_id[wq_tail] = rid;
        wq_wr[wq_tail] = writer;
        wq_tail = (wq_tail + 1) % WQ_DEPTH;
        wq_count++;
        return 1'b1;
    endfunction

    function automatic logic [ID_PORT_W-1:0] pop_waiter();
        logic [ID_PORT_W-1:0] rid;
        rid = wq_id[wq_head];
        wq_head = (wq_head + 1) % WQ_DEPTH;
        wq_count--;
        return rid;
    endfunction

    // Head writer if allowed, else the leading run of readers.
    function automatic void wake_waiters(bit allow_writer);
        if (wq_count == 0)
            return;
        if (wq_wr[wq_head])
        begin
            if (!allow_writer)
                return;
            hold_cnt = HOLD_WRITER;
            emit_event(EV_WOKE_WRITER, pop_waiter());
            return;
        end
        while (wq_count > 0 && !wq_wr[wq_head] && step_events.size() < MAX_WAKE)
        begin
            if (hold_cnt < HOLD_MAX)
                hold_cnt++;
            emit_event(EV_WOKE_READER, pop_waiter());
        end
    endfunction

    function automatic void predict_lock_events(logic [OPCODE_W-1:0] op,
                                                logic [ID_PORT_W-1:0] rid);
        ev_kind_t k;
        step_events.delete();
        case (op)
            OP_READ, OP_TRY_READ:
            begin
                if (hold_cnt >= 0 && wq_count == 0)
                begin
                    if (hold_cnt >= HOLD_MAX)
                    begin
                        k = EV_REFUSED;
                    end
                    else
                    begin
                        hold_cnt++;
                        k = EV_GRANTED;
                    end
                end
                else if (op == OP_TRY_READ)
                begin
                    k = EV_TRY_FAILED;
                end
                else
                begin
                    k = push_waiter(rid, 1'b0) ? EV_QUEUED : EV_REFUSED;
                end
            end
            OP_WRITE, OP_TRY_WRITE:
            begin
                if (hold_cnt == 0 && wq_count == 0)
                begin
                    hold_cnt = HOLD_WRITER;
                    k = EV_GRANTED;
                end
                else if (op == OP_TRY_WRITE)
                begin
                    k = EV_TRY_FAILED;
                end
                else
                begin
                    k = push_waiter(rid, 1'b1) ? EV_QUEUED : EV_REFUSED;
                end
            end
            OP_REL_READ:
            begin
                if (hold_cnt <= 0)
                begin
                    k = EV_REFUSED;
                end
                else
                begin
                    hold_cnt--;
                    k = EV_RELEASED;
                    if (hold_cnt == 0)
                        wake_waiters(1'b1);
                end
            end
            OP_REL_WRITE, OP_DOWNGRADE:
            begin
                hold_cnt = (op == OP_REL_WRITE) ? 16'sd0 : HOLD_ONE;
                k = EV_RELEASED;
                wake_waiters(op == OP_REL_WRITE);
            end
            default:
            begin
                k = EV_REFUSED;
            end
        endcase
        if (step_events.size() == 0)
            emit_event(k, rid);
        step_events[step_events.size() - 1].last = 1'b1;
    endfunction

    // Mostly sound requests for the current owner, with some noise.
    function automatic logic [OPCODE_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return OPCODE_W'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (hold_cnt < 0)
        begin
            if (r < 35) return OP_READ;
            if (r < 55) return OP_WRITE;
            if (r < 60) return OP_TRY_READ;
            if (r < 65) return OP_TRY_WRITE;
            if (r < 90) return OP_REL_WRITE;
            return OP_DOWNGRADE;
        end
        if (hold_cnt > 0)
        begin
            if (r < 35) return OP_READ;
            if (r < 50) return OP_WRITE;
            if (r < 60) return OP_TRY_READ;
            if (r < 65) return OP_TRY_WRITE;
            return OP_REL_READ;
        end
        if (r < 40) return OP_READ;
        if (r < 70) return OP_WRITE;
        if (r < 85) return OP_TRY_READ;
        return OP_TRY_WRITE;
    endfunction

    task automatic report_mismatch(string field, logic signed [HOLD_W:0] want,
                                   logic signed [HOLD_W:0] got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        err_count++;
    endtask

    task automatic send_req(logic [OPCODE_W-1:0] op, logic [ID_PORT_W-1:0] rid, bit typed,
                            ev_kind_t kind, logic signed [HOLD_W-1:0] hold);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 6)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid    <= 1'b1;
        opcode       <= op;
        requester_id <= rid;
        typed_on     <= typed;
        typed_kind   <= kind;
        typed_hold   <= hold;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (lock_events_due.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
        rsp_stall <= !calm && ($urandom_range(0, 99) < 6);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        lock_event_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (lock_events_due.size() == 0)
                begin
                    $display("%0t: unexpected result kind %0d task %0d hold %0d last %0d",
                             $time, event_kind, task_id, hold_count, last);
                    err_count++;
                end
                else
                begin
                    want = lock_events_due.pop_front();
                    if (event_kind !== want.kind)
                        report_mismatch("event_kind", REPORT_W'(want.kind),
                                        REPORT_W'(event_kind));
                    if (task_id !== want.tid)
                        report_mismatch("task_id", REPORT_W'(want.tid), REPORT_W'(task_id));
                    if (hold_count !== want.hold)
                        report_mismatch("hold_count", REPORT_W'(want.hold),
                                        REPORT_W'(hold_count));
                    if (last !== want.last)
                        report_mismatch("last", REPORT_W'(want.last), REPORT_W'(last));
                end
            end
            if (req_valid && !req_stall)
            begin
                predict_lock_events(opcode, requester_id);
                if (typed_on)
                    lock_events_due.push_back('{typed_kind, requester_id, typed_hold, 1'b1});
                else
                    lock_events_due = {lock_events_due, step_events};
            end
        end
    end

    initial
    begin
        plan_row_t row;
        logic [ID_PORT_W-1:0] rid;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_PLAN[i])
        begin
            row = DIRECTED_PLAN[i];
            for (int n = 0; n < row.reps; n++)
            begin
                rid = row.rand_rid ? ID_PORT_W'($urandom_range(0, 255)) : row.rid;
                send_req(row.op, rid, row.typed, row.kind, row.hold);
            end
        end
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 200 && i < 330);
            if (i % 150 == 149)
                drain_results();
            send_req(pick_op(), ID_PORT_W'($urandom_range(0, 255)), 1'b0, EV_GRANTED, '0);
        end
        calm = 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
